### rtl/sobi_pkg.sv
// Shared types and constants for the segment / oriented box intersection pipeline.
`timescale 1ns / 1ps

package sobi_pkg;

   localparam int COMPONENT_BITS_DEF = 21;
   localparam int FIELD_W            = 63;
   localparam int TIME_W             = 17;
   localparam int CSR_INDEX_W        = 4;
   localparam int CSR_DATA_W         = 12;

   localparam logic [TIME_W-1:0] TIME_ONE = 17'd65536;
   localparam logic [TIME_W-1:0] TIME_SAT = 17'd65537;

   localparam logic [CSR_DATA_W-1:0] PARALLEL_EPSILON_RESET = 12'd1;
   localparam logic [CSR_DATA_W-1:0] FACE_TOLERANCE_RESET   = 12'd4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PARALLEL_EPSILON = 4'd0,
      CSR_FACE_TOLERANCE   = 4'd1
   } csr_index_type;

   typedef struct packed {
      logic [FIELD_W-1:0] seg_start;
      logic [FIELD_W-1:0] seg_end;
      logic [FIELD_W-1:0] box_center;
      logic [FIELD_W-1:0] box_axis_x;
      logic [FIELD_W-1:0] box_axis_y;
      logic [FIELD_W-1:0] box_axis_z;
      logic [FIELD_W-1:0] box_half_sizes;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [TIME_W-1:0]  entry_time;
      logic [FIELD_W-1:0] hit_point;
      logic [FIELD_W-1:0] face_normal;
      logic               normal_found;
   } rsp_type;

endpackage

### rtl/segment_oriented_box_intersect.sv
// Top level: segment versus oriented box slab test with control registers.
// Pipeline: front stages A to D, then the divider, then back stages E to J up to rsp_valid.
// Throughput: one word per cycle while rsp_stall is low; every stage is registered and bubbles close up on stall.
// The divider is 17 quotient-bit stages over six lanes plus one saturate/sign stage.
// Reset (synchronous): clears all valid bits; parallel_epsilon = 1, face_tolerance = 4.
`timescale 1ns / 1ps

module segment_oriented_box_intersect import sobi_pkg::*; #(
   parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int CB     = COMPONENT_BITS;
   localparam int DW     = 2 * CB + 3;
   localparam int NW     = 2 * CB + 4;
   localparam int SIDE_W = 21 * CB + 7;
   localparam int TW     = TIME_W + 1;

   logic [CSR_DATA_W-1:0] eps_ff, tol_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= PARALLEL_EPSILON_RESET;
         tol_ff <= FACE_TOLERANCE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PARALLEL_EPSILON: eps_ff <= csr_data;
            CSR_FACE_TOLERANCE:   tol_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic              front_ready, front_valid, div_ready, div_valid, face_ready;
   logic [6*NW-1:0]   an;
   logic [6*DW-1:0]   af;
   logic [5:0]        neg;
   logic [SIDE_W-1:0] side_f, side_d;
   logic [6*TW-1:0]   tv;

   sobi_front #(.CB(CB)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .in_req    (req_payload),
      .par_eps   (eps_ff),
      .out_valid (front_valid),
      .out_ready (div_ready),
      .out_an    (an),
      .out_af    (af),
      .out_neg   (neg),
      .out_side  (side_f)
   );

   sobi_div #(.CB(CB)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (div_ready),
      .in_an     (an),
      .in_af     (af),
      .in_neg    (neg),
      .in_side   (side_f),
      .out_valid (div_valid),
      .out_ready (face_ready),
      .out_t     (tv),
      .out_side  (side_d)
   );

   sobi_face #(.CB(CB)) u_face (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (face_ready),
      .in_t      (tv),
      .in_side   (side_d),
      .face_tol  (tol_ff),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_rsp   (rsp_payload)
   );

   assign req_stall = !front_ready;

   // a free output means the whole ready chain is open
   a_no_stall_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("req stalled while rsp side is free");

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.hit |->
         rsp_payload.entry_time == '0 && rsp_payload.hit_point == '0 &&
         rsp_payload.face_normal == '0 && !rsp_payload.normal_found)
      else $error("miss word carries non-zero fields");

   a_normal_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.normal_found |-> rsp_payload.hit)
      else $error("normal found on a miss");

   a_time_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.entry_time <= TIME_ONE)
      else $error("entry time above one");

   a_no_normal_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.normal_found |-> rsp_payload.face_normal == '0)
      else $error("normal set without a face");

endmodule

### rtl/sobi_front.sv
// Front end: unpack, segment direction and offset, axis projections, slab numerators.
`timescale 1ns / 1ps

module sobi_front import sobi_pkg::*; #(
   parameter int CB = COMPONENT_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  req_type              in_req,
   input  logic [11:0]          par_eps,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [6*(2*CB+4)-1:0] out_an,
   output logic [6*(2*CB+3)-1:0] out_af,
   output logic [5:0]           out_neg,
   output logic [21*CB+6:0]     out_side
);

   localparam int V      = CB + 1;
   localparam int PW     = 2 * CB + 1;
   localparam int DW     = 2 * CB + 3;
   localparam int NW     = 2 * CB + 4;
   localparam int O_S    = 0;
   localparam int O_C    = 3 * CB;
   localparam int O_DIR  = 6 * CB;
   localparam int O_AX   = 9 * CB + 3;
   localparam int O_HS   = 18 * CB + 3;
   localparam int BASE_W = 21 * CB + 3;
   localparam int SIDE_W = BASE_W + 4;
   localparam int NST    = 4;

   logic [NST-1:0] v_ff;
   logic [NST:0]   rdy;

   always_comb begin
      rdy[NST] = out_ready;
      for (int k = NST - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         for (int k = 1; k < NST; k++) begin
            if (rdy[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[NST-1];

   // stage A: unpack, direction, start offset, clamp half sizes
   logic [BASE_W-1:0]   side_a_in, side_a_ff;
   logic signed [V-1:0] loc_a_in [3];
   logic signed [V-1:0] loc_a_ff [3];

   always_comb begin
      logic signed [CB-1:0] st, en, ce, hr;
      side_a_in = '0;
      for (int i = 0; i < 3; i++) begin
         st = $signed(in_req.seg_start[i*CB +: CB]);
         en = $signed(in_req.seg_end[i*CB +: CB]);
         ce = $signed(in_req.box_center[i*CB +: CB]);
         hr = $signed(in_req.box_half_sizes[i*CB +: CB]);
         loc_a_in[i] = V'(st) - V'(ce);
         side_a_in[O_S + i*CB +: CB]  = st;
         side_a_in[O_C + i*CB +: CB]  = ce;
         side_a_in[O_DIR + i*V +: V]  = V'(en) - V'(st);
         side_a_in[O_AX + i*CB +: CB]        = in_req.box_axis_x[i*CB +: CB];
         side_a_in[O_AX + (3+i)*CB +: CB]    = in_req.box_axis_y[i*CB +: CB];
         side_a_in[O_AX + (6+i)*CB +: CB]    = in_req.box_axis_z[i*CB +: CB];
         side_a_in[O_HS + i*CB +: CB] = hr[CB-1] ? '0 : hr;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         side_a_ff <= side_a_in;
         loc_a_ff  <= loc_a_in;
      end
   end

   // stage B: axis by offset and axis by direction products
   logic [BASE_W-1:0]    side_b_ff;
   logic signed [PW-1:0] pe_b_in [9];
   logic signed [PW-1:0] pf_b_in [9];
   logic signed [PW-1:0] pe_b_ff [9];
   logic signed [PW-1:0] pf_b_ff [9];

   always_comb begin
      logic signed [CB-1:0] axv;
      logic signed [V-1:0]  dv;
      for (int a = 0; a < 3; a++) begin
         for (int j = 0; j < 3; j++) begin
            axv = $signed(side_a_ff[O_AX + (a*3+j)*CB +: CB]);
            dv  = $signed(side_a_ff[O_DIR + j*V +: V]);
            pe_b_in[a*3+j] = axv * loc_a_ff[j];
            pf_b_in[a*3+j] = axv * dv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         side_b_ff <= side_a_ff;
         pe_b_ff   <= pe_b_in;
         pf_b_ff   <= pf_b_in;
      end
   end

   // stage C: dot product sums
   logic [BASE_W-1:0]    side_c_ff;
   logic signed [DW-1:0] e_c_in [3];
   logic signed [DW-1:0] f_c_in [3];
   logic signed [DW-1:0] e_c_ff [3];
   logic signed [DW-1:0] f_c_ff [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         e_c_in[a] = DW'(pe_b_ff[a*3]) + DW'(pe_b_ff[a*3+1]) + DW'(pe_b_ff[a*3+2]);
         f_c_in[a] = DW'(pf_b_ff[a*3]) + DW'(pf_b_ff[a*3+1]) + DW'(pf_b_ff[a*3+2]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         side_c_ff <= side_b_ff;
         e_c_ff    <= e_c_in;
         f_c_ff    <= f_c_in;
      end
   end

   // stage D: slab numerators, magnitudes, parallel test
   logic [6*NW-1:0]   an_d_in, an_d_ff;
   logic [6*DW-1:0]   af_d_in, af_d_ff;
   logic [5:0]        neg_d_in, neg_d_ff;
   logic [SIDE_W-1:0] side_d_in, side_d_ff;

   always_comb begin
      logic signed [NW-1:0] hx, ex, n1, n2;
      logic signed [DW-1:0] fx;
      logic [DW-1:0]        afv;
      logic [2:0]           par;
      logic                 pm;
      pm = 1'b0;
      for (int a = 0; a < 3; a++) begin
         hx  = $signed({{(NW-CB-12){1'b0}}, side_c_ff[O_HS + a*CB +: CB], 12'd0});
         ex  = NW'(e_c_ff[a]);
         fx  = f_c_ff[a];
         n1  = -hx - ex;
         n2  = hx - ex;
         afv = fx[DW-1] ? $unsigned(-fx) : $unsigned(fx);
         an_d_in[(2*a)*NW +: NW]   = n1[NW-1] ? $unsigned(-n1) : $unsigned(n1);
         an_d_in[(2*a+1)*NW +: NW] = n2[NW-1] ? $unsigned(-n2) : $unsigned(n2);
         af_d_in[(2*a)*DW +: DW]   = afv;
         af_d_in[(2*a+1)*DW +: DW] = afv;
         neg_d_in[2*a]   = n1[NW-1] ^ fx[DW-1];
         neg_d_in[2*a+1] = n2[NW-1] ^ fx[DW-1];
         par[a] = afv <= {{(DW-24){1'b0}}, par_eps, 12'd0};
         pm = pm | (par[a] && ((ex < -hx) || (ex > hx)));
      end
      side_d_in = {pm, par, side_c_ff};
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         an_d_ff   <= an_d_in;
         af_d_ff   <= af_d_in;
         neg_d_ff  <= neg_d_in;
         side_d_ff <= side_d_in;
      end
   end

   assign out_an   = an_d_ff;
   assign out_af   = af_d_ff;
   assign out_neg  = neg_d_ff;
   assign out_side = side_d_ff;

endmodule

### rtl/sobi_div.sv
// Six-lane pipelined restoring divider for slab times, one quotient bit per stage.
`timescale 1ns / 1ps

module sobi_div import sobi_pkg::*; #(
   parameter int CB = COMPONENT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [6*(2*CB+4)-1:0] in_an,
   input  logic [6*(2*CB+3)-1:0] in_af,
   input  logic [5:0]            in_neg,
   input  logic [21*CB+6:0]      in_side,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [6*(TIME_W+1)-1:0] out_t,
   output logic [21*CB+6:0]      out_side
);

   localparam int DW     = 2 * CB + 3;
   localparam int NW     = 2 * CB + 4;
   localparam int SIDE_W = 21 * CB + 7;
   localparam int LANES  = 6;
   localparam int QST    = TIME_W;
   localparam int NST    = TIME_W + 1;
   localparam int TW     = TIME_W + 1;

   logic [NST-1:0] v_ff;
   logic [NST:0]   rdy;

   always_comb begin
      rdy[NST] = out_ready;
      for (int k = NST - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         for (int k = 1; k < NST; k++) begin
            if (rdy[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[NST-1];

   logic [DW:0]         rem_in [QST][LANES];
   logic [DW:0]         rem_ff [QST][LANES];
   logic [TIME_W-1:0]   q_in   [QST][LANES];
   logic [TIME_W-1:0]   q_ff   [QST][LANES];
   logic [DW-1:0]       af_in  [QST][LANES];
   logic [DW-1:0]       af_ff  [QST][LANES];
   logic [LANES-1:0]    sat_in [QST];
   logic [LANES-1:0]    sat_ff [QST];
   logic [LANES-1:0]    neg_in [QST];
   logic [LANES-1:0]    neg_ff [QST];
   logic [SIDE_W-1:0]   side_in [NST];
   logic [SIDE_W-1:0]   side_ff [NST];
   logic signed [TW-1:0] t_in [LANES];
   logic signed [TW-1:0] t_ff [LANES];

   always_comb begin
      logic [NW-1:0]     an;
      logic [DW-1:0]     af;
      logic [DW:0]       r;
      logic              ge;
      logic [TIME_W-1:0] qs;
      // first stage: quotient of two or more saturates, else take the top bit
      for (int l = 0; l < LANES; l++) begin
         an = in_an[l*NW +: NW];
         af = in_af[l*DW +: DW];
         sat_in[0][l] = an >= {af, 1'b0};
         r  = an[DW:0];
         ge = r >= {1'b0, af};
         rem_in[0][l] = ge ? r - {1'b0, af} : r;
         q_in[0][l]   = '0;
         q_in[0][l][TIME_W-1] = ge;
         af_in[0][l]  = af;
         neg_in[0][l] = in_neg[l];
      end
      side_in[0] = in_side;
      for (int k = 1; k < QST; k++) begin
         for (int l = 0; l < LANES; l++) begin
            r  = {rem_ff[k-1][l][DW-1:0], 1'b0};
            ge = r >= {1'b0, af_ff[k-1][l]};
            rem_in[k][l] = ge ? r - {1'b0, af_ff[k-1][l]} : r;
            q_in[k][l]   = q_ff[k-1][l];
            q_in[k][l][TIME_W-1-k] = ge;
            af_in[k][l]  = af_ff[k-1][l];
         end
         sat_in[k]  = sat_ff[k-1];
         neg_in[k]  = neg_ff[k-1];
         side_in[k] = side_ff[k-1];
      end
      // last stage: saturate and apply sign
      for (int l = 0; l < LANES; l++) begin
         qs = (sat_ff[QST-1][l] || (q_ff[QST-1][l] > TIME_SAT)) ? TIME_SAT : q_ff[QST-1][l];
         t_in[l] = neg_ff[QST-1][l] ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
      end
      side_in[NST-1] = side_ff[NST-2];
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QST; k++) begin
         if (rdy[k]) begin
            rem_ff[k] <= rem_in[k];
            q_ff[k]   <= q_in[k];
            af_ff[k]  <= af_in[k];
            sat_ff[k] <= sat_in[k];
            neg_ff[k] <= neg_in[k];
         end
      end
      for (int k = 0; k < NST; k++) begin
         if (rdy[k]) side_ff[k] <= side_in[k];
      end
      if (rdy[NST-1]) t_ff <= t_in;
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_t[l*TW +: TW] = t_ff[l];
      end
   end

   assign out_side = side_ff[NST-1];

endmodule

### rtl/sobi_face.sv
// Back end: interval combine, hit point, face projection and selection, result register.
`timescale 1ns / 1ps

module sobi_face import sobi_pkg::*; #(
   parameter int CB = COMPONENT_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [6*(TIME_W+1)-1:0] in_t,
   input  logic [21*CB+6:0]        in_side,
   input  logic [11:0]             face_tol,
   output logic                    out_valid,
   input  logic                    out_ready,
   output rsp_type                 out_rsp
);

   localparam int V      = CB + 1;
   localparam int TW     = TIME_W + 1;
   localparam int MW     = V + TW;
   localparam int LW     = CB + 2;
   localparam int HW2    = LW + CB;
   localparam int PJW    = HW2 + 2;
   localparam int CW     = PJW + 1;
   localparam int O_S    = 0;
   localparam int O_C    = 3 * CB;
   localparam int O_DIR  = 6 * CB;
   localparam int O_AX   = 9 * CB + 3;
   localparam int O_HS   = 18 * CB + 3;
   localparam int BASE_W = 21 * CB + 3;
   localparam int NST    = 6;

   logic [NST-1:0] v_ff;
   logic [NST:0]   rdy;

   always_comb begin
      rdy[NST] = out_ready;
      for (int k = NST - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         for (int k = 1; k < NST; k++) begin
            if (rdy[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[NST-1];

   // stage E: narrow [0,1] by each non-parallel slab
   logic [BASE_W-1:0] base_e_ff;
   logic [TIME_W-1:0] tmin_e_in, tmin_e_ff;
   logic              hit_e_in, hit_e_ff;

   always_comb begin
      logic signed [TW-1:0] t1, t2, lo, hi, tmin, tmax;
      logic [2:0]           par;
      tmin = '0;
      tmax = $signed({1'b0, TIME_ONE});
      par  = in_side[BASE_W +: 3];
      for (int a = 0; a < 3; a++) begin
         t1 = $signed(in_t[(2*a)*TW +: TW]);
         t2 = $signed(in_t[(2*a+1)*TW +: TW]);
         lo = (t1 > t2) ? t2 : t1;
         hi = (t1 > t2) ? t1 : t2;
         if (!par[a]) begin
            if (lo > tmin) tmin = lo;
            if (hi < tmax) tmax = hi;
         end
      end
      hit_e_in  = !in_side[BASE_W+3] && (tmin <= tmax);
      tmin_e_in = (tmin > $signed({1'b0, TIME_ONE})) ? TIME_ONE : tmin[TIME_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         base_e_ff <= in_side[BASE_W-1:0];
         tmin_e_ff <= tmin_e_in;
         hit_e_ff  <= hit_e_in;
      end
   end

   // stage F: direction times entry time
   logic [BASE_W-1:0]    base_f_ff;
   logic [TIME_W-1:0]    tmin_f_ff;
   logic                 hit_f_ff;
   logic signed [MW-1:0] prod_f_in [3];
   logic signed [MW-1:0] prod_f_ff [3];

   always_comb begin
      logic signed [V-1:0] dv;
      for (int i = 0; i < 3; i++) begin
         dv = $signed(base_e_ff[O_DIR + i*V +: V]);
         prod_f_in[i] = dv * $signed({1'b0, tmin_e_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         base_f_ff <= base_e_ff;
         tmin_f_ff <= tmin_e_ff;
         hit_f_ff  <= hit_e_ff;
         prod_f_ff <= prod_f_in;
      end
   end

   // stage G: round half up, hit point and its offset from the centre
   logic [BASE_W-1:0]    base_g_ff;
   logic [TIME_W-1:0]    tmin_g_ff;
   logic                 hit_g_ff;
   logic [CB-1:0]        pt_g_in [3];
   logic [CB-1:0]        pt_g_ff [3];
   logic signed [LW-1:0] lp_g_in [3];
   logic signed [LW-1:0] lp_g_ff [3];

   always_comb begin
      logic signed [MW-1:0] sh;
      logic signed [LW-1:0] pt;
      for (int i = 0; i < 3; i++) begin
         sh = (prod_f_ff[i] + MW'(32768)) >>> 16;
         pt = LW'($signed(base_f_ff[O_S + i*CB +: CB])) + $signed(sh[LW-1:0]);
         pt_g_in[i] = pt[CB-1:0];
         lp_g_in[i] = pt - LW'($signed(base_f_ff[O_C + i*CB +: CB]));
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         base_g_ff <= base_f_ff;
         tmin_g_ff <= tmin_f_ff;
         hit_g_ff  <= hit_f_ff;
         pt_g_ff   <= pt_g_in;
         lp_g_ff   <= lp_g_in;
      end
   end

   // stage H: offset by axis products
   logic [BASE_W-1:0]     base_h_ff;
   logic [TIME_W-1:0]     tmin_h_ff;
   logic                  hit_h_ff;
   logic [CB-1:0]         pt_h_ff [3];
   logic signed [HW2-1:0] pp_h_in [9];
   logic signed [HW2-1:0] pp_h_ff [9];

   always_comb begin
      logic signed [CB-1:0] axv;
      for (int a = 0; a < 3; a++) begin
         for (int j = 0; j < 3; j++) begin
            axv = $signed(base_g_ff[O_AX + (a*3+j)*CB +: CB]);
            pp_h_in[a*3+j] = lp_g_ff[j] * axv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         base_h_ff <= base_g_ff;
         tmin_h_ff <= tmin_g_ff;
         hit_h_ff  <= hit_g_ff;
         pt_h_ff   <= pt_g_ff;
         pp_h_ff   <= pp_h_in;
      end
   end

   // stage I: projection against face extent less tolerance
   logic [BASE_W-1:0] base_i_ff;
   logic [TIME_W-1:0] tmin_i_ff;
   logic              hit_i_ff;
   logic [CB-1:0]     pt_i_ff [3];
   logic [2:0]        match_i_in, match_i_ff;
   logic [2:0]        pos_i_in, pos_i_ff;

   always_comb begin
      logic signed [PJW-1:0] proj;
      logic signed [CW-1:0]  ap, lim;
      for (int a = 0; a < 3; a++) begin
         proj = PJW'(pp_h_ff[a*3]) + PJW'(pp_h_ff[a*3+1]) + PJW'(pp_h_ff[a*3+2]);
         ap   = proj[PJW-1] ? -CW'(proj) : CW'(proj);
         lim  = $signed({{(CW-CB-12){1'b0}}, base_h_ff[O_HS + a*CB +: CB], 12'd0})
              - $signed({{(CW-24){1'b0}}, face_tol, 12'd0});
         match_i_in[a] = ap >= lim;
         pos_i_in[a]   = proj > 0;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         base_i_ff  <= base_h_ff;
         tmin_i_ff  <= tmin_h_ff;
         hit_i_ff   <= hit_h_ff;
         pt_i_ff    <= pt_h_ff;
         match_i_ff <= match_i_in;
         pos_i_ff   <= pos_i_in;
      end
   end

   // stage J: first matching face, signed normal, result word
   rsp_type rsp_in, rsp_ff;

   always_comb begin
      logic [1:0]           sel;
      logic                 found;
      logic signed [CB-1:0] axv, nv;
      logic [FIELD_W-1:0]   hp, nrm;
      sel   = '0;
      found = 1'b0;
      for (int a = 0; a < 3; a++) begin
         if (!found && match_i_ff[a]) begin
            sel   = 2'(a);
            found = 1'b1;
         end
      end
      hp  = '0;
      nrm = '0;
      for (int j = 0; j < 3; j++) begin
         axv = $signed(base_i_ff[O_AX + (sel*3+j)*CB +: CB]);
         if (pos_i_ff[sel]) begin
            nv = axv;
         end else if (axv == $signed({1'b1, {(CB-1){1'b0}}})) begin
            nv = $signed({1'b0, {(CB-1){1'b1}}});
         end else begin
            nv = -axv;
         end
         hp[j*CB +: CB]  = pt_i_ff[j];
         nrm[j*CB +: CB] = nv;
      end
      rsp_in = '0;
      if (hit_i_ff) begin
         rsp_in.hit          = 1'b1;
         rsp_in.entry_time   = tmin_i_ff;
         rsp_in.hit_point    = hp;
         rsp_in.face_normal  = found ? nrm : '0;
         rsp_in.normal_found = found;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[5]) rsp_ff <= rsp_in;
   end

   assign out_rsp = rsp_ff;

endmodule
